// ===== rtl/boq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the box overlap table query block
// no dependencies
package boq_pkg;

   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int COORD_W = 16;
   localparam int RAW_W   = 32;
   localparam int AXES    = 3;
   localparam int NCOORD  = 2 * AXES;
   localparam int QCNT_W  = 3;
   localparam int BOX_W   = NCOORD * COORD_W;

   localparam logic signed [COORD_W-1:0] Q_LOW  = -16'sd32768;
   localparam logic signed [COORD_W-1:0] Q_HIGH = 16'sd32767;

   localparam logic [QCNT_W-1:0] QCNT_LAST = 3'd5;
   localparam logic [QCNT_W-1:0] QCNT_MAX0 = 3'd3;

   typedef enum logic [1:0] {
      OP_SET       = 2'd0,
      OP_CLEAR     = 2'd1,
      OP_CLEAR_ALL = 2'd2,
      OP_QUERY     = 2'd3
   } boq_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUANT,
      ST_WRITE,
      ST_SCAN,
      ST_FINISH
   } boq_state_type;

endpackage

// ===== rtl/boq_quant.sv =====
`timescale 1ns / 1ps
// shared quantizer: q23.8 to 16-bit integer, floor or ceil, saturated
// depends on boq_pkg
module boq_quant #(
   parameter int FRAC_BITS = 8
) (
   input  logic signed [boq_pkg::RAW_W-1:0]   raw,
   input  logic                               round_up,
   output logic signed [boq_pkg::COORD_W-1:0] q
);
   import boq_pkg::*;

   localparam logic signed [RAW_W:0] BIAS   = (33'sd1 <<< FRAC_BITS) - 33'sd1;
   localparam logic signed [RAW_W:0] LO_EXT = -33'sd32768;
   localparam logic signed [RAW_W:0] HI_EXT = 33'sd32767;

   logic signed [RAW_W:0] ext;
   logic signed [RAW_W:0] biased;
   logic signed [RAW_W:0] shifted;

   always_comb begin
      ext     = {raw[RAW_W-1], raw};
      biased  = ext + (round_up ? BIAS : '0);
      shifted = biased >>> FRAC_BITS;
      priority if (shifted < LO_EXT) begin
         q = Q_LOW;
      end else if (shifted > HI_EXT) begin
         q = Q_HIGH;
      end else begin
         q = shifted[COORD_W-1:0];
      end
   end

endmodule

// ===== rtl/box_overlap_table_query.sv =====
`timescale 1ns / 1ps
// box overlap table: set, clear, clear all and query over stored 3-d boxes
// set runs accept, six quantizer passes and a table write; clears complete at accept
// query runs six quantizer passes, then scans the table up to the high water mark,
// one table entry per cycle through the single compare unit, plus stalls while results wait
// reset clears the valid bits, the high water mark and the output valid bit;
// table contents stay unknown and are masked by the valid bits
module box_overlap_table_query #(
   parameter int ENTRIES   = 64,
   parameter int FRAC_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index, min_x, min_y, min_z, max_x, max_y, max_z, zero pad
   input  logic [199:0] req_tdata,
   // opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit_index, hit_count, zero pad
   output logic [15:0]  rsp_tdata,
   // is_hit
   output logic         rsp_tuser,
   // is_last
   output logic         rsp_tlast
);
   import boq_pkg::*;

   localparam int DEPTH = (ENTRIES < 64) ? ENTRIES : 64;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   boq_state_type state_ff, state_in;
   boq_op_type    op_ff, op_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic signed [RAW_W-1:0]          raw_ff [NCOORD];
   logic signed [RAW_W-1:0]          raw_in [NCOORD];
   logic [QCNT_W-1:0]                qcnt_ff, qcnt_in;
   logic signed [COORD_W-1:0]        coord_ff [NCOORD];
   logic signed [COORD_W-1:0]        coord_in [NCOORD];
   logic [DEPTH-1:0]                 vld_ff, vld_in;
   logic [CNT_W-1:0]                 hw_ff, hw_in;
   logic [CNT_W-1:0]                 addr_ff, addr_in;
   logic                             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic                             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]                 pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]                 hit_cnt_ff, hit_cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]                 rsp_idx_ff, rsp_idx_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [CNT_W-1:0]                 rsp_cnt_ff, rsp_cnt_in;

   logic [BOX_W-1:0] box_mem [DEPTH];
   logic [BOX_W-1:0] rd_data_ff;
   logic             ent_vld_ff;

   logic                      accept;
   logic                      issue_vld;
   logic                      out_free;
   logic                      stall;
   logic                      cmp_hit;
   logic                      rd_en;
   logic                      mem_we;
   logic                      idx_ok;
   logic                      req_idx_ok;
   logic signed [COORD_W-1:0] q_out;
   logic [IDX_W-1:0]          req_idx;
   logic [CNT_W-1:0]          idx_plus;

   boq_quant #(
      .FRAC_BITS(FRAC_BITS)
   ) u_quant (
      .raw      (raw_ff[qcnt_ff]),
      .round_up (qcnt_ff >= QCNT_MAX0),
      .q        (q_out)
   );

   // overlap test, touching faces count
   always_comb begin
      logic ok;
      logic signed [COORD_W-1:0] emin;
      logic signed [COORD_W-1:0] emax;
      ok = ent_vld_ff;
      for (int a = 0; a < AXES; a++) begin
         emin = rd_data_ff[a*COORD_W +: COORD_W];
         emax = rd_data_ff[(a+AXES)*COORD_W +: COORD_W];
         if (coord_ff[a+AXES] < emin || coord_ff[a] > emax) begin
            ok = 1'b0;
         end
      end
      cmp_hit = ok;
   end

   assign req_idx    = req_tdata[IDX_W-1:0];
   assign req_idx_ok = CNT_W'(req_idx) < DEPTH_C;
   assign idx_ok     = CNT_W'(idx_ff) < DEPTH_C;
   assign idx_plus   = CNT_W'(idx_ff) + CNT_W'(1);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign issue_vld  = addr_ff < hw_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stall      = cmp_vld_ff && cmp_hit && pend_vld_ff && !out_free;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      raw_in      = raw_ff;
      qcnt_in     = qcnt_ff;
      coord_in    = coord_ff;
      vld_in      = vld_ff;
      hw_in       = hw_ff;
      addr_in     = addr_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in  = rsp_hit_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rd_en       = 1'b0;
      mem_we      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = boq_op_type'(req_tuser);
               idx_in = req_idx;
               for (int k = 0; k < NCOORD; k++) begin
                  raw_in[k] = req_tdata[IDX_W + k*RAW_W +: RAW_W];
               end
               unique case (boq_op_type'(req_tuser))
                  OP_SET, OP_QUERY: begin
                     qcnt_in  = '0;
                     state_in = ST_QUANT;
                  end
                  OP_CLEAR: begin
                     if (req_idx_ok) begin
                        vld_in[req_idx[AW-1:0]] = 1'b0;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     vld_in = '0;
                     hw_in  = '0;
                  end
               endcase
            end
         end
         ST_QUANT: begin
            coord_in[qcnt_ff] = q_out;
            if (qcnt_ff == QCNT_LAST) begin
               addr_in     = '0;
               cmp_vld_in  = 1'b0;
               pend_vld_in = 1'b0;
               hit_cnt_in  = '0;
               state_in    = (op_ff == OP_SET) ? ST_WRITE : ST_SCAN;
            end else begin
               qcnt_in = qcnt_ff + QCNT_W'(1);
            end
         end
         ST_WRITE: begin
            if (idx_ok) begin
               mem_we = 1'b1;
               vld_in[idx_ff[AW-1:0]] = 1'b1;
               if (idx_plus > hw_ff) begin
                  hw_in = idx_plus;
               end
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (!stall) begin
               rd_en      = issue_vld;
               cmp_vld_in = issue_vld;
               cmp_idx_in = IDX_W'(addr_ff);
               if (issue_vld) begin
                  addr_in = addr_ff + CNT_W'(1);
               end
               if (cmp_vld_ff && cmp_hit) begin
                  hit_cnt_in  = hit_cnt_ff + CNT_W'(1);
                  pend_vld_in = 1'b1;
                  pend_idx_in = cmp_idx_ff;
                  if (pend_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = 1'b1;
                     rsp_idx_in   = pend_idx_ff;
                     rsp_last_in  = 1'b0;
                     rsp_cnt_in   = '0;
                  end
               end
               if (!cmp_vld_ff && !issue_vld) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = pend_vld_ff;
               rsp_idx_in   = pend_vld_ff ? pend_idx_ff : '0;
               rsp_last_in  = 1'b1;
               rsp_cnt_in   = hit_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         hw_ff        <= '0;
         cmp_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         hw_ff        <= hw_in;
         cmp_vld_ff   <= cmp_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      raw_ff      <= raw_in;
      qcnt_ff     <= qcnt_in;
      coord_ff    <= coord_in;
      addr_ff     <= addr_in;
      cmp_idx_ff  <= cmp_idx_in;
      pend_idx_ff <= pend_idx_in;
      hit_cnt_ff  <= hit_cnt_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // box table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         box_mem[idx_ff[AW-1:0]] <= {coord_ff[5], coord_ff[4], coord_ff[3],
                                     coord_ff[2], coord_ff[1], coord_ff[0]};
      end
      if (rd_en) begin
         rd_data_ff <= box_mem[addr_ff[AW-1:0]];
         ent_vld_ff <= vld_ff[addr_ff[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_cnt_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for box_overlap_table_query: directed and random set, clear and query requests
// keeps its own box table to predict every hit result; depends on rtl/boq_pkg.sv and the rtl
module tb;
   import boq_pkg::*;

   localparam int FRAC     = 8;
   localparam int SLOTS    = 64;
   localparam int RAW_MIN  = 32'h80000000;
   localparam int RAW_MAX  = 32'h7fffffff;
   localparam int LIMIT    = 3000000;
   localparam int DRAIN    = 40;

   typedef struct packed {
      boq_op_type                   op;
      logic [IDX_W-1:0]             idx;
      logic [AXES-1:0][RAW_W-1:0]   lo;
      logic [AXES-1:0][RAW_W-1:0]   hi;
   } box_req_t;

   typedef struct packed {
      logic             is_hit;
      logic [IDX_W-1:0] hit_index;
      logic             is_last;
      logic [CNT_W-1:0] hit_count;
   } hit_rsp_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [15:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   // predicted table
   logic signed [COORD_W-1:0] tab_lo [SLOTS][AXES];
   logic signed [COORD_W-1:0] tab_hi [SLOTS][AXES];
   logic                      tab_valid [SLOTS];
   int                        high_mark;

   hit_rsp_t expected_hits [$];
   int       fail_count = 0;
   int       cycle_count = 0;
   bit       send_idle = 1'b1;
   bit       stall_on = 1'b1;
   int       stall_left = 0;
   int       stall_len;

   box_overlap_table_query uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, expected_hits.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         stall_len = stall_on ? $urandom_range(0, 15) : 0;
         if (stall_len != 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_len;
         end
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      hit_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hits.size() == 0) begin
            $display("%0t unexpected result: is_hit %0b hit_index %0d is_last %0b hit_count %0d",
                     $time, rsp_tuser, rsp_tdata[5:0], rsp_tlast, rsp_tdata[12:6]);
            fail_count++;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_tuser !== want.is_hit) begin
               $display("%0t is_hit mismatch: expected %0b actual %0b",
                        $time, want.is_hit, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[5:0] !== want.hit_index) begin
               $display("%0t hit_index mismatch: expected %0d actual %0d",
                        $time, want.hit_index, rsp_tdata[5:0]);
               fail_count++;
            end
            if (rsp_tlast !== want.is_last) begin
               $display("%0t is_last mismatch: expected %0b actual %0b",
                        $time, want.is_last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tdata[12:6] !== want.hit_count) begin
               $display("%0t hit_count mismatch: expected %0d actual %0d",
                        $time, want.hit_count, rsp_tdata[12:6]);
               fail_count++;
            end
         end
      end
   end

   function automatic logic signed [COORD_W-1:0] clamp_coord(logic signed [63:0] w);
      if (w < Q_LOW) return Q_LOW;
      if (w > Q_HIGH) return Q_HIGH;
      return w[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] floor_coord(logic signed [RAW_W-1:0] v);
      logic signed [63:0] w;
      w = v;
      return clamp_coord(w >>> FRAC);
   endfunction

   function automatic logic signed [COORD_W-1:0] ceil_coord(logic signed [RAW_W-1:0] v);
      logic signed [63:0] w;
      w = v;
      w = w + ((64'sd1 <<< FRAC) - 64'sd1);
      return clamp_coord(w >>> FRAC);
   endfunction

   function automatic void clear_slot(int i);
      for (int a = 0; a < AXES; a++) begin
         tab_lo[i][a] = Q_HIGH;
         tab_hi[i][a] = -16'sd32767;
      end
      tab_valid[i] = 1'b0;
   endfunction

   // update the predicted table and queue the hits a query produces
   function automatic void predict_request(box_req_t r);
      logic signed [COORD_W-1:0] qlo [AXES];
      logic signed [COORD_W-1:0] qhi [AXES];
      int       found [$];
      logic     match;
      hit_rsp_t e;
      for (int a = 0; a < AXES; a++) begin
         qlo[a] = floor_coord($signed(r.lo[a]));
         qhi[a] = ceil_coord($signed(r.hi[a]));
      end
      case (r.op)
         OP_SET: begin
            for (int a = 0; a < AXES; a++) begin
               tab_lo[r.idx][a] = qlo[a];
               tab_hi[r.idx][a] = qhi[a];
            end
            tab_valid[r.idx] = 1'b1;
            if (int'(r.idx) + 1 > high_mark) high_mark = int'(r.idx) + 1;
         end
         OP_CLEAR: clear_slot(r.idx);
         OP_CLEAR_ALL: begin
            for (int i = 0; i < SLOTS; i++) clear_slot(i);
            high_mark = 0;
         end
         default: begin
            for (int i = 0; i < high_mark; i++) begin
               match = tab_valid[i];
               for (int a = 0; a < AXES; a++) begin
                  if (qhi[a] < tab_lo[i][a] || qlo[a] > tab_hi[i][a]) match = 1'b0;
               end
               if (match) found.push_back(i);
            end
            if (found.size() == 0) begin
               e = '{is_hit: 1'b0, hit_index: '0, is_last: 1'b1, hit_count: '0};
               expected_hits.push_back(e);
            end
            for (int k = 0; k < found.size(); k++) begin
               e.is_hit    = 1'b1;
               e.hit_index = IDX_W'(found[k]);
               e.is_last   = (k == found.size() - 1);
               e.hit_count = e.is_last ? CNT_W'(found.size()) : '0;
               expected_hits.push_back(e);
            end
         end
      endcase
   endfunction

   task automatic send_request(box_req_t r);
      int gap;
      gap = send_idle ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {2'b00, r.hi[2], r.hi[1], r.hi[0], r.lo[2], r.lo[1], r.lo[0], r.idx};
      req_tuser  <= r.op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(r);
   endtask

   function automatic box_req_t cube_req(boq_op_type op, int idx, int lo, int hi);
      box_req_t r;
      r.op  = op;
      r.idx = IDX_W'(idx);
      for (int a = 0; a < AXES; a++) begin
         r.lo[a] = lo;
         r.hi[a] = hi;
      end
      return r;
   endfunction

   function automatic box_req_t random_req(boq_op_type op);
      box_req_t r;
      int kind;
      int c;
      int h;
      r.op  = op;
      r.idx = IDX_W'($urandom_range(0, SLOTS - 1));
      kind  = $urandom_range(0, 9);
      for (int a = 0; a < AXES; a++) begin
         if (kind < 2) begin
            r.lo[a] = $urandom;
            r.hi[a] = $urandom;
         end else begin
            if (kind == 2) begin
               // near the saturation limits
               c = 32760 * 256 + $urandom_range(0, 16 * 256);
               if ($urandom_range(0, 1) == 1) c = -c;
            end else begin
               c = $urandom_range(0, 40 * 256) - 20 * 256;
            end
            h = $urandom_range(0, 8 * 256);
            r.lo[a] = c - h;
            r.hi[a] = c + h;
         end
      end
      return r;
   endfunction

   function automatic boq_op_type random_op();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return OP_SET;
      if (pick < 50) return OP_CLEAR;
      if (pick < 52) return OP_CLEAR_ALL;
      return OP_QUERY;
   endfunction

   task automatic test_empty_table();
      send_request(cube_req(OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube_req(OP_QUERY, 9, 0, 256));
   endtask

   task automatic test_extremes();
      box_req_t r;
      send_request(cube_req(OP_SET, 0, RAW_MIN, RAW_MAX));
      // inverted box at the top slot
      send_request(cube_req(OP_SET, 63, RAW_MAX, RAW_MIN));
      // fraction rounding: floor of minima, ceiling of maxima
      r = cube_req(OP_SET, 5, -1, 1);
      r.lo[1] = -256;
      r.hi[1] = 256;
      r.lo[2] = -257;
      r.hi[2] = 257;
      send_request(r);
      send_request(cube_req(OP_SET, 6, 10 * 256, 12 * 256));
      // touching faces
      send_request(cube_req(OP_QUERY, 0, 12 * 256, 20 * 256));
      send_request(cube_req(OP_QUERY, 0, 12 * 256 + 1, 20 * 256));
      send_request(cube_req(OP_QUERY, 0, 13 * 256, 20 * 256));
      send_request(cube_req(OP_QUERY, 0, 0, 0));
      send_request(cube_req(OP_QUERY, 0, RAW_MIN, RAW_MAX));
      // inverted test box
      send_request(cube_req(OP_QUERY, 0, RAW_MAX, RAW_MIN));
   endtask

   task automatic test_clears();
      send_request(cube_req(OP_CLEAR, 0, 0, 0));
      send_request(cube_req(OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube_req(OP_CLEAR, 63, 0, 0));
      send_request(cube_req(OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube_req(OP_SET, 63, -256, 256));
      send_request(cube_req(OP_QUERY, 0, -512, 512));
      send_request(cube_req(OP_CLEAR_ALL, 0, 0, 0));
      send_request(cube_req(OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube_req(OP_SET, 3, -1000, 1000));
      send_request(cube_req(OP_QUERY, 0, RAW_MIN, RAW_MAX));
      send_request(cube_req(OP_CLEAR_ALL, 0, 0, 0));
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         send_request(random_req(random_op()));
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) clear_slot(i);
      high_mark = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_extremes();
      test_clears();
      test_random(200);
      send_idle = 1'b0;
      stall_on  = 1'b0;
      test_random(75);
      send_idle = 1'b1;
      test_random(40);
      send_idle = 1'b0;
      stall_on  = 1'b1;
      test_random(40);
      req_tvalid <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
